FILE: rtl/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

  // Defaults for the top-level parameters
  localparam int MaxFramesDef = 16;
  localparam int PageWidthDef = 16;

  // Fixed port widths
  localparam int CfgWidth     = 5;
  localparam int PageIoWidth  = 16;
  localparam int FrameIoWidth = 4;
  localparam int TotalWidth   = 32;

  // Reset value of the frame count register
  localparam logic [CfgWidth-1:0] FramesReset = CfgWidth'(16);

  // Depth of the queue between front and back
  localparam int QueueDepth = 2;

  // Index width that never drops to zero
  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WAIT,
    BK_UPDATE
  } back_state_t;

endpackage

FILE: rtl/lrupr_ram.sv
`timescale 1ns / 1ps

module lrupr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]              wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lrupr_front.sv
`timescale 1ns / 1ps

module lrupr_front
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = MaxFramesDef,
  parameter int PAGE_WIDTH = PageWidthDef,
  localparam int CNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [PageIoWidth-1:0] page_number,
  input  logic                   cfg_wr_en,
  input  logic [CfgWidth-1:0]    cfg_wr_data,
  output logic                   q_avail,
  input  logic                   q_pop,
  output logic [PAGE_WIDTH-1:0]  q_page,
  output logic [CNT_W-1:0]       q_count
);

  localparam int PTR_W = idx_width(QueueDepth);
  localparam int OCC_W = $clog2(QueueDepth + 1);

  logic [CfgWidth-1:0]   frames_in_use;
  logic [CNT_W-1:0]      n_clamp;
  logic [PAGE_WIDTH-1:0] page_masked;
  logic                  push;

  logic [PAGE_WIDTH-1:0] ent_page [QueueDepth];
  logic [CNT_W-1:0]      ent_count [QueueDepth];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [OCC_W-1:0]      occ;

  // Frame count register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FramesReset;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  // Classify: clamp the frame count and keep only the page bits in use
  always_comb begin
    if (frames_in_use == '0) begin
      n_clamp = CNT_W'(1);
    end else if (int'(frames_in_use) > MAX_FRAMES) begin
      n_clamp = CNT_W'(MAX_FRAMES);
    end else begin
      n_clamp = CNT_W'(frames_in_use);
    end
    page_masked = PAGE_WIDTH'(page_number);
  end

  assign busy = (int'(occ) == QueueDepth);
  assign push = start && !busy;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_page[wr_ptr]  <= page_masked;
      ent_count[wr_ptr] <= n_clamp;
    end
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == QueueDepth - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (int'(rd_ptr) == QueueDepth - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !q_pop) begin
        occ <= occ + OCC_W'(1);
      end else if (q_pop && !push) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

  assign q_avail = (occ != '0);
  assign q_page  = ent_page[rd_ptr];
  assign q_count = ent_count[rd_ptr];

endmodule

FILE: rtl/lrupr_back.sv
`timescale 1ns / 1ps

module lrupr_back
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = MaxFramesDef,
  parameter int PAGE_WIDTH = PageWidthDef,
  localparam int CNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_avail,
  output logic                    q_pop,
  input  logic [PAGE_WIDTH-1:0]   q_page,
  input  logic [CNT_W-1:0]        q_count,
  output logic                    done,
  output logic                    hit,
  output logic [FrameIoWidth-1:0] frame_index,
  output logic                    evicted_valid,
  output logic [PageIoWidth-1:0]  evicted_page,
  output logic [TotalWidth-1:0]   fault_count,
  output logic [TotalWidth-1:0]   hit_count
);

  localparam int IDX_W = idx_width(MAX_FRAMES);
  localparam int AW    = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2);

  back_state_t state, state_next;

  // Current word
  logic [PAGE_WIDTH-1:0] cur_page;
  logic [CNT_W-1:0]      cur_count;

  // Scan issue and compare stage
  logic [IDX_W-1:0] scan_idx;
  logic             scan_last;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             ram_rd_en;
  logic [PAGE_WIDTH-1:0] ram_rd_data;

  // Candidates gathered over the scan
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      hit_rank;
  logic                  emp_found;
  logic [IDX_W-1:0]      emp_idx;
  logic [IDX_W-1:0]      lru_idx;
  logic [IDX_W-1:0]      lru_rank;
  logic [PAGE_WIDTH-1:0] lru_page;

  // Per-frame state
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [IDX_W-1:0]      recency_rank [MAX_FRAMES];
  logic [IDX_W-1:0]      rank_next [MAX_FRAMES];
  logic [CNT_W-1:0]      valid_cnt;

  // Totals
  logic [TotalWidth-1:0] fault_total;
  logic [TotalWidth-1:0] hit_total;

  // Update decision
  logic             upd_en;
  logic [IDX_W-1:0] sel_idx;
  logic             sel_was_valid;
  logic [IDX_W-1:0] sel_rank;
  logic [CNT_W-1:0] others;
  logic             wr_en;

  // Frame page store
  lrupr_ram #(
    .WIDTH (PAGE_WIDTH),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(sel_idx)),
    .wr_data (cur_page),
    .rd_en   (ram_rd_en),
    .rd_addr (AW'(scan_idx)),
    .rd_data (ram_rd_data)
  );

  assign scan_last = (CNT_W'(scan_idx) == cur_count - CNT_W'(1));

  // Next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_rd_en  = 1'b0;
    upd_en     = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_avail) begin
          q_pop      = 1'b1;
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        ram_rd_en = 1'b1;
        if (scan_last) begin
          state_next = BK_WAIT;
        end
      end
      BK_WAIT: begin
        state_next = BK_UPDATE;
      end
      BK_UPDATE: begin
        upd_en     = 1'b1;
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // State register and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      cmp_vld  <= 1'b0;
      scan_idx <= '0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == BK_SCAN);
      if (state == BK_IDLE) begin
        scan_idx <= '0;
      end else if (state == BK_SCAN && !scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  // Latch the word and compare index
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_page  <= q_page;
      cur_count <= q_count;
    end
    cmp_idx <= scan_idx;
  end

  // Compare stage: first match, first empty, lowest rank (first on a tie)
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hit_found <= 1'b0;
      emp_found <= 1'b0;
    end else if (cmp_vld) begin
      if (!hit_found && frame_valid[cmp_idx] && ram_rd_data == cur_page) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_rank  <= recency_rank[cmp_idx];
      end
      if (!emp_found && !frame_valid[cmp_idx]) begin
        emp_found <= 1'b1;
        emp_idx   <= cmp_idx;
      end
      if (cmp_idx == '0 || recency_rank[cmp_idx] < lru_rank) begin
        lru_idx  <= cmp_idx;
        lru_rank <= recency_rank[cmp_idx];
        lru_page <= ram_rd_data;
      end
    end
  end

  // Pick the frame and work out the new ranks
  always_comb begin
    if (hit_found) begin
      sel_idx = hit_idx;
    end else if (emp_found) begin
      sel_idx = emp_idx;
    end else begin
      sel_idx = lru_idx;
    end
    sel_was_valid = hit_found || !emp_found;
    sel_rank      = hit_found ? hit_rank : lru_rank;
    others        = sel_was_valid ? valid_cnt - CNT_W'(1) : valid_cnt;
    wr_en         = upd_en && !hit_found;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (IDX_W'(i) == sel_idx) begin
        rank_next[i] = IDX_W'(others);
      end else if (sel_was_valid && frame_valid[i] && recency_rank[i] > sel_rank) begin
        rank_next[i] = recency_rank[i] - IDX_W'(1);
      end else begin
        rank_next[i] = recency_rank[i];
      end
    end
  end

  // Frame state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      valid_cnt   <= '0;
      fault_total <= '0;
      hit_total   <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (upd_en) begin
      frame_valid[sel_idx] <= 1'b1;
      if (!sel_was_valid) begin
        valid_cnt <= valid_cnt + CNT_W'(1);
      end
      for (int i = 0; i < MAX_FRAMES; i++) begin
        recency_rank[i] <= rank_next[i];
      end
      if (hit_found) begin
        hit_total <= (hit_total == '1) ? hit_total : hit_total + TotalWidth'(1);
      end else begin
        fault_total <= (fault_total == '1) ? fault_total : fault_total + TotalWidth'(1);
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= upd_en;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (upd_en) begin
      hit           <= hit_found;
      frame_index   <= FrameIoWidth'(sel_idx);
      evicted_valid <= !sel_was_valid ? 1'b0 : !hit_found;
      evicted_page  <= (!hit_found && !emp_found) ? PageIoWidth'(lru_page) : '0;
      fault_count   <= hit_found ? fault_total
                     : ((fault_total == '1) ? fault_total : fault_total + TotalWidth'(1));
      hit_count     <= !hit_found ? hit_total
                     : ((hit_total == '1) ? hit_total : hit_total + TotalWidth'(1));
    end
  end

endmodule

FILE: rtl/lru_page_replacement_top.sv
`timescale 1ns / 1ps

// LRU page replacement over a fully associative set of frames. Pulse start
// with a page number while busy is low; the word goes into a two-deep queue
// and busy rises only when that queue is full. The back end scans the frames
// in use (frames_in_use, clamped to 1..MAX_FRAMES) one per cycle through the
// single read port of the frame page RAM, and the result appears on the
// result ports for exactly one cycle with done high. Results cannot be
// stalled: sample them whenever done is high. Write frames_in_use only while
// the block is idle. No clearing pass is needed after reset; frame valid
// bits live in flip-flops.

module lru_page_replacement_top
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = MaxFramesDef,
  parameter int PAGE_WIDTH = PageWidthDef
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [PageIoWidth-1:0]  page_number,
  input  logic                    cfg_wr_en,
  input  logic [CfgWidth-1:0]     cfg_wr_data,
  output logic                    done,
  output logic                    hit,
  output logic [FrameIoWidth-1:0] frame_index,
  output logic                    evicted_valid,
  output logic [PageIoWidth-1:0]  evicted_page,
  output logic [TotalWidth-1:0]   fault_count,
  output logic [TotalWidth-1:0]   hit_count
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  logic                  q_avail;
  logic                  q_pop;
  logic [PAGE_WIDTH-1:0] q_page;
  logic [CNT_W-1:0]      q_count;

  lrupr_front #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_WIDTH (PAGE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .page_number (page_number),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_avail     (q_avail),
    .q_pop       (q_pop),
    .q_page      (q_page),
    .q_count     (q_count)
  );

  lrupr_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_WIDTH (PAGE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_avail       (q_avail),
    .q_pop         (q_pop),
    .q_page        (q_page),
    .q_count       (q_count),
    .done          (done),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .hit_count     (hit_count)
  );

  // Between words the back end returns to idle and scans again, so done never fires twice in a row
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe on consecutive cycles");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evicted_valid && evicted_page == '0))
    else $error("eviction reported on a hit");

  // The queue is empty right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy high right after reset");

endmodule
